FILE: hdl/angle_sensor_filter_velocity_defines.svh
// ----------------------------------------------------------------------------
// Angle sensor filter assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef ANGLE_SENSOR_FILTER_VELOCITY_DEFINES_SVH
`define ANGLE_SENSOR_FILTER_VELOCITY_DEFINES_SVH

// same-cycle implication
`define ASFV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASFV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/asfv_pkg.sv
// ----------------------------------------------------------------------------
// Angle sensor filter package
// Opcodes, register indexes, sequencer states and shared helpers.
// ----------------------------------------------------------------------------
package asfv_pkg;

  localparam int unsigned DIV_W = 44;
  localparam int unsigned DEN_W = 32;
  localparam int unsigned CNT_W = 6;

  localparam logic [16:0] COEFF_ONE = 17'd32768;

  typedef enum logic [1:0] {
    OP_SAMPLE     = 2'd0,
    OP_SET_ANGLE  = 2'd1,
    OP_SET_OFFSET = 2'd2,
    OP_HOLD       = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_GAIN   = 3'd0,
    CFG_BIAS   = 3'd1,
    CFG_RANGE  = 3'd2,
    CFG_ACOEFF = 3'd3,
    CFG_VCOEFF = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CAL, ST_OFS, ST_INST, ST_LPA1, ST_LPA2, ST_VEL, ST_DIVV,
    ST_VFLT, ST_LPV1, ST_LPV2, ST_REDA, ST_REDA_W, ST_REDI, ST_REDI_W, ST_OUT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [15:0] clamp_coeff(input logic [15:0] v);
    logic [15:0] r;
    if ({1'b0, v} > COEFF_ONE) r = COEFF_ONE[15:0];
    else r = v;
    return r;
  endfunction

endpackage

FILE: hdl/asfv_div.sv
// ----------------------------------------------------------------------------
// Angle sensor filter divider
// Restoring unsigned divider, one quotient bit per cycle, MSB-aligned dividend.
// ----------------------------------------------------------------------------
module asfv_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  asfv_pkg::div_req_t          req_i,
  input  logic [asfv_pkg::DIV_W-1:0]  dividend_i,
  input  logic [asfv_pkg::DEN_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [asfv_pkg::DIV_W-1:0]  quotient_o,
  output logic [asfv_pkg::DEN_W-1:0]  remainder_o
);
  import asfv_pkg::*;

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] work_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_q, work_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.nbits;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      den_q  <= divisor_i;
    end else if (busy_q) begin
      work_q <= {work_q[DIV_W-2:0], ge};
      rem_q  <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = work_q;
  assign remainder_o = rem_q;

endmodule

FILE: hdl/angle_sensor_filter_velocity.sv
// ----------------------------------------------------------------------------
// Angle sensor filter with wrapped velocity
// Calibrates ADC words to Q16.16 degrees, low-pass filters angle and velocity.
//
//   channel | signals                                  | direction
//   in      | in_valid_i / in_stall_o + word fields    | to block
//   out     | out_valid_o / out_stall_i + word fields  | from block
//   cfg     | cfg_valid_i / cfg_ready_o, index, data   | to block
//
// A sample word runs calibration, angle filter, velocity division, velocity
// filter and two range reductions, each as needed; set and hold words go from
// calibration to the reductions. The 44-bit velocity division and two 32-bit
// range reductions share the one restoring divider. Idle lies between words.
// One word is in work at a time; the result waits in registers while
// out_stall_i is high. Registers are written only while idle.
// Reset clears all filter state, no clearing pass.
// ----------------------------------------------------------------------------
module angle_sensor_filter_velocity #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              opcode_i,
  input  logic [SAMPLE_BITS-1:0]  raw_sample_i,
  input  logic [31:0]             time_ms_i,
  input  logic signed [31:0]      set_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [30:0]             angle_wrapped_o,
  output logic signed [31:0]      angle_unwrapped_o,
  output logic [30:0]             instant_wrapped_o,
  output logic signed [47:0]      velocity_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [2:0]              cfg_index_i,
  input  logic [31:0]             cfg_data_i
);
  import asfv_pkg::*;

  state_e state_q, state_d;

  logic signed [31:0] gain_q, bias_q;
  logic [30:0]        range_q;
  logic [15:0]        acoeff_q, vcoeff_q;

  logic signed [31:0] zo_q, fa_q, prev_angle_q;
  logic               afr_q, vr_q, vfr_q;
  logic [31:0]        prev_time_q;
  logic signed [47:0] fv_q;

  op_e                    op_q;
  logic [SAMPLE_BITS-1:0] raw_q;
  logic [31:0]            time_q;
  logic signed [31:0]     setv_q, inst_q;
  logic signed [47:0]     prod_q, vel_q;
  logic signed [72:0]     acc_q;
  logic                   neg_q;
  logic [30:0]            aw_q, iw_q;

  logic signed [47:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [72:0] product;
  logic signed [72:0] acc_sum;
  logic signed [49:0] cal_sum;
  logic signed [31:0] cal;
  logic signed [32:0] dlt;
  logic signed [33:0] dwrap;
  logic signed [44:0] num, num_mag;
  logic [31:0]        dt;
  logic               vel_skip;
  logic signed [31:0] red_src;
  logic [31:0]        red_mag;
  logic [30:0]        red_res;

  div_req_t           div_req;
  logic [DIV_W-1:0]   div_dividend;
  logic [DEN_W-1:0]   div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic [DEN_W-1:0]   div_rem;

  asfv_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign product = mul_a * mul_b;
  assign acc_sum = acc_q + product;
  assign cal_sum = 50'(prod_q) + 50'(bias_q) - 50'(zo_q);
  assign cal     = sat32(cal_sum);

  assign dlt   = 33'(fa_q) - 33'(prev_angle_q);
  assign dt    = time_q - prev_time_q;
  assign vel_skip = !vr_q || (dt == '0);

  always_comb begin
    dwrap = 34'(dlt);
    if ($signed({dlt, 1'b0}) > $signed({3'b000, range_q})) begin
      dwrap = 34'(dlt) - $signed({3'b000, range_q});
    end else if ($signed({dlt, 1'b0}) < -$signed({3'b000, range_q})) begin
      dwrap = 34'(dlt) + $signed({3'b000, range_q});
    end
  end

  assign num     = (45'(dwrap) <<< 10) - (45'(dwrap) <<< 4) - (45'(dwrap) <<< 3);
  assign num_mag = (num < 0) ? -num : num;

  assign red_src = (state_q == ST_REDA) ? fa_q : inst_q;
  assign red_mag = red_src[31] ? 32'(-33'(red_src)) : red_src;
  assign red_res = (neg_q && (div_rem != '0)) ? 31'({1'b0, range_q} - div_rem)
                                              : div_rem[30:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_CAL;
      ST_CAL:    state_d = ST_OFS;
      ST_OFS:    state_d = ST_INST;
      ST_INST: begin
        if (op_q != OP_SAMPLE) state_d = ST_REDA;
        else if (afr_q) state_d = ST_LPA1;
        else state_d = ST_VEL;
      end
      ST_LPA1:   state_d = ST_LPA2;
      ST_LPA2:   state_d = ST_VEL;
      ST_VEL:    state_d = vel_skip ? ST_VFLT : ST_DIVV;
      ST_DIVV:   if (div_done) state_d = ST_VFLT;
      ST_VFLT:   state_d = vfr_q ? ST_LPV1 : ST_REDA;
      ST_LPV1:   state_d = ST_LPV2;
      ST_LPV2:   state_d = ST_REDA;
      ST_REDA:   state_d = ST_REDA_W;
      ST_REDA_W: if (div_done) state_d = ST_REDI;
      ST_REDI:   state_d = ST_REDI_W;
      ST_REDI_W: if (div_done) state_d = ST_OUT;
      ST_OUT:    if (!out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a        = '0;
    mul_b        = '0;
    div_req      = '0;
    div_dividend = '0;
    div_divisor  = {1'b0, range_q};
    unique case (state_q)
      ST_CAL: begin
        mul_a = 48'(gain_q);
        mul_b = $signed(25'(raw_q));
      end
      ST_LPA1: begin
        mul_a = 48'(inst_q);
        mul_b = $signed({8'b0, 1'b0, acoeff_q});
      end
      ST_LPA2: begin
        mul_a = 48'(fa_q);
        mul_b = $signed({8'b0, COEFF_ONE - {1'b0, acoeff_q}});
      end
      ST_LPV1: begin
        mul_a = vel_q;
        mul_b = $signed({8'b0, 1'b0, vcoeff_q});
      end
      ST_LPV2: begin
        mul_a = fv_q;
        mul_b = $signed({8'b0, COEFF_ONE - {1'b0, vcoeff_q}});
      end
      ST_VEL: begin
        div_req.start = !vel_skip;
        div_req.nbits = CNT_W'(DIV_W);
        div_dividend  = num_mag[DIV_W-1:0];
        div_divisor   = dt;
      end
      ST_REDA, ST_REDI: begin
        div_req.start = 1'b1;
        div_req.nbits = CNT_W'(DEN_W);
        div_dividend  = {red_mag, (DIV_W-DEN_W)'(0)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      gain_q       <= 32'sd16777216;
      bias_q       <= '0;
      range_q      <= 31'd23592960;
      acoeff_q     <= COEFF_ONE[15:0];
      vcoeff_q     <= 16'd4915;
      zo_q         <= '0;
      fa_q         <= '0;
      afr_q        <= 1'b0;
      prev_angle_q <= '0;
      prev_time_q  <= '0;
      vr_q         <= 1'b0;
      fv_q         <= '0;
      vfr_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_GAIN:   gain_q <= cfg_data_i;
          CFG_BIAS:   bias_q <= cfg_data_i;
          CFG_RANGE:  if (cfg_data_i[30:0] != '0) range_q <= cfg_data_i[30:0];
          CFG_ACOEFF: acoeff_q <= clamp_coeff(cfg_data_i[15:0]);
          CFG_VCOEFF: begin
            vcoeff_q <= clamp_coeff(cfg_data_i[15:0]);
            vfr_q    <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      unique case (state_q)
        ST_OFS: begin
          if (op_q == OP_SET_ANGLE || op_q == OP_SET_OFFSET) begin
            zo_q <= (op_q == OP_SET_ANGLE)
                    ? sat32(50'(zo_q) + 50'(cal) - 50'(setv_q)) : setv_q;
            fa_q         <= setv_q;
            afr_q        <= 1'b1;
            vr_q         <= 1'b0;
            vfr_q        <= 1'b0;
            prev_angle_q <= '0;
            prev_time_q  <= '0;
            fv_q         <= '0;
          end
        end
        ST_INST: begin
          if (op_q == OP_SET_OFFSET || (op_q == OP_SAMPLE && !afr_q)) begin
            fa_q  <= cal;
            afr_q <= 1'b1;
          end
        end
        ST_LPA2: fa_q <= acc_sum[46:15];
        ST_VEL: begin
          prev_angle_q <= fa_q;
          prev_time_q  <= time_q;
          vr_q         <= 1'b1;
        end
        ST_VFLT: begin
          if (!vfr_q) begin
            fv_q  <= vel_q;
            vfr_q <= 1'b1;
          end
        end
        ST_LPV2: fv_q <= acc_sum[62:15];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_q   <= op_e'(opcode_i);
          raw_q  <= raw_sample_i;
          time_q <= time_ms_i;
          setv_q <= set_value_i;
        end
      end
      ST_CAL:  prod_q <= product[55:8];
      ST_INST: inst_q <= cal;
      ST_LPA1, ST_LPV1: acc_q <= product;
      ST_VEL: begin
        neg_q <= num < 0;
        vel_q <= '0;
      end
      ST_DIVV: begin
        if (div_done) vel_q <= neg_q ? -$signed(48'(div_quot))
                                     : $signed(48'(div_quot));
      end
      ST_REDA, ST_REDI: neg_q <= red_src[31];
      ST_REDA_W: if (div_done) aw_q <= red_res;
      ST_REDI_W: if (div_done) iw_q <= red_res;
      default: begin
      end
    endcase
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = (state_q == ST_OUT);
  assign angle_wrapped_o   = aw_q;
  assign angle_unwrapped_o = fa_q;
  assign instant_wrapped_o = iw_q;
  assign velocity_o        = fv_q;
  assign cfg_ready_o       = (state_q == ST_IDLE);

endmodule

FILE: hdl/asfv_checker.sv
// ----------------------------------------------------------------------------
// Angle sensor filter port checker
// Watches the handshakes of the top level over time.
// ----------------------------------------------------------------------------
`include "angle_sensor_filter_velocity_defines.svh"

module asfv_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  `ASFV_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "out word dropped")
  `ASFV_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "not busy")
  `ASFV_ASSERT_NOW(a_no_accept_pending, in_valid_i && !in_stall_o, !out_valid_o, "overlap")
  `ASFV_ASSERT_NEXT(a_single_result, out_valid_o && !out_stall_i, !out_valid_o, "repeat")

endmodule

bind angle_sensor_filter_velocity asfv_checker u_asfv_checker (.*);
